/* src/psi_pkg.sv */
package psi_pkg;

  localparam int NUM_PUMPS_DEF = 2;
  localparam int CFG_AW        = 5;

  // floor(x / 1000) for any 32-bit x is (x * DIV1000_MUL) >> DIV1000_SH
  localparam logic [31:0] DIV1000_MUL = 32'd274877907;
  localparam int          DIV1000_SH  = 38;
  localparam int          SECS_W      = 23;
  localparam logic [25:0] MS_PER_SEC  = 26'd1000;
  localparam logic [7:0]  PCT_MAX     = 8'd100;

  typedef enum logic [2:0] {
    MODE_OFF     = 3'd0,
    MODE_ON      = 3'd1,
    MODE_DRY     = 3'd2,
    MODE_RUNTIME = 3'd3,
    MODE_SENSOR  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    RES_GRANTED = 3'd0,
    RES_DRY     = 3'd1,
    RES_SENSOR  = 3'd2,
    RES_RUNTIME = 3'd3,
    RES_INVALID = 3'd4
  } res_e;

  typedef enum logic [2:0] {
    CFG_MIN_WATER  = 3'd0,
    CFG_SOIL_THR   = 3'd1,
    CFG_AUTO_MODE  = 3'd2,
    CFG_MAX_PUMP   = 3'd3,
    CFG_HYST       = 3'd4,
    CFG_COOLDOWN   = 3'd5,
    CFG_MAX_MANUAL = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    mode_e       mode;
    logic        relay;
    logic        demand;
    logic [31:0] start;
    logic [31:0] lock_dl;
    logic [31:0] run_dl;
  } pump_st_t;

  typedef struct packed {
    logic [6:0]  min_water;
    logic [6:0]  soil_thr;
    logic        auto_mode;
    logic [25:0] max_run_ms;
    logic [6:0]  hyst;
    logic [26:0] cooldown;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic [31:0] now;
    logic [6:0]  tank;
    logic        tank_err;
    logic [6:0]  soil;
    logic        soil_err;
    logic        desired;
    logic        dur_nz;
    logic [25:0] dur_ms;
  } item_t;

  typedef struct packed {
    pump_st_t    st;
    res_e        res;
    logic        stop;
    logic [31:0] stop_ms;
  } step_t;

endpackage

/* src/psi_step.sv */
module psi_step import psi_pkg::*; (
  input  cfg_t     cfg_i,
  input  item_t    item_i,
  input  pump_st_t cur_i,
  output step_t    step_o
);

  function automatic logic pending(input logic [31:0] now, input logic [31:0] dl);
    logic [31:0] d;
    d = dl - now;
    return (dl != '0) && (d != '0) && !d[31];
  endfunction

  function automatic logic [31:0] make_dl(input logic [31:0] sum);
    return (sum == '0) ? 32'd1 : sum;
  endfunction

  // relay off; a timed run reports its elapsed milliseconds
  function automatic step_t drive_off(input step_t w, input logic [31:0] now);
    step_t r;
    r = w;
    if (w.st.relay) begin
      r.st.relay = 1'b0;
      if (w.st.start != '0) begin
        r.stop    = 1'b1;
        r.stop_ms = now - w.st.start;
      end
      r.st.start = '0;
    end
    return r;
  endfunction

  logic [7:0]  rel_sum;
  logic [7:0]  rel;
  logic [7:0]  dry_rel;
  logic [31:0] run_el;
  step_t       w;

  assign rel_sum = {1'b0, cfg_i.soil_thr} + {1'b0, cfg_i.hyst};
  assign rel     = (rel_sum > PCT_MAX) ? PCT_MAX : rel_sum;
  assign dry_rel = {1'b0, cfg_i.min_water} + {1'b0, cfg_i.hyst};

  always_comb begin
    w        = '0;
    w.st     = cur_i;
    w.res    = RES_GRANTED;
    run_el   = '0;
    if (!item_i.op) begin
      // hard lockouts and lockout release
      if (item_i.tank_err) begin
        w         = drive_off(w, item_i.now);
        w.st.mode = MODE_SENSOR;
      end else if (item_i.tank < cfg_i.min_water) begin
        w         = drive_off(w, item_i.now);
        w.st.mode = MODE_DRY;
      end else if (w.st.mode == MODE_RUNTIME && pending(item_i.now, w.st.lock_dl)) begin
        w = drive_off(w, item_i.now);
      end else begin
        if (w.st.mode == MODE_DRY && {1'b0, item_i.tank} >= dry_rel) w.st.mode = MODE_OFF;
        if (w.st.mode == MODE_SENSOR) w.st.mode = MODE_OFF;
        if (w.st.mode == MODE_RUNTIME) begin
          w.st.mode    = MODE_OFF;
          w.st.lock_dl = '0;
        end
      end
      // auto demand with hysteresis band
      if (cfg_i.auto_mode) begin
        if (item_i.soil_err) w.st.demand = 1'b0;
        else if (item_i.soil < cfg_i.soil_thr) w.st.demand = 1'b1;
        else if ({1'b0, item_i.soil} > rel) w.st.demand = 1'b0;
      end
      // manual run timer and demand following
      if (w.st.mode == MODE_OFF || w.st.mode == MODE_ON) begin
        if (w.st.run_dl != '0 && !pending(item_i.now, w.st.run_dl)) begin
          w           = drive_off(w, item_i.now);
          w.st.mode   = MODE_OFF;
          w.st.run_dl = '0;
          w.st.demand = 1'b0;
        end else if (w.st.demand && !w.st.relay) begin
          w.st.relay = 1'b1;
          w.st.start = item_i.now;
          w.st.mode  = MODE_ON;
        end else if (!w.st.demand && w.st.relay) begin
          w           = drive_off(w, item_i.now);
          w.st.mode   = MODE_OFF;
          w.st.run_dl = '0;
        end
      end
      // runtime trip arms the cooldown
      run_el = item_i.now - w.st.start;
      if (w.st.mode == MODE_ON && w.st.start != '0 && run_el >= {6'b0, cfg_i.max_run_ms}) begin
        w            = drive_off(w, item_i.now);
        w.st.mode    = MODE_RUNTIME;
        w.st.run_dl  = '0;
        w.st.lock_dl = make_dl(item_i.now + {5'b0, cfg_i.cooldown});
        w.st.demand  = 1'b0;
      end
    end else begin
      if (!item_i.desired) begin
        w.st.demand = 1'b0;
        w.st.run_dl = '0;
      end else begin
        if (item_i.tank_err) w.res = RES_SENSOR;
        else if (item_i.tank < cfg_i.min_water) w.res = RES_DRY;
        else if (w.st.mode == MODE_RUNTIME) w.res = RES_RUNTIME;
        else if (w.st.mode == MODE_SENSOR) w.res = RES_SENSOR;
        else if (w.st.mode == MODE_DRY) w.res = RES_DRY;
        if (w.res == RES_GRANTED) begin
          w.st.demand = 1'b1;
          w.st.run_dl = item_i.dur_nz ? make_dl(item_i.now + {6'b0, item_i.dur_ms}) : '0;
        end
      end
    end
    step_o = w;
  end

endmodule

/* src/pump_safety_interlock.sv */
// channel   | handshake                  | payload
// input     | in_valid_i / in_stall_o    | operation, pump_index, now_ms, levels, request
// result    | out_valid_o / out_stall_i  | pump_echo, relay_on, pump_state, request_result,
//           |                            | stopped_seconds, run_seconds_today
// config    | psel/penable/pwrite/pready | paddr, pwdata, prdata
// one request per clock while in_stall_o is low; each request passes through every stage to the result
// the four stages are input capture, pump state update, /1000 multiply, run total
// stalled results back up into empty stages first; in_stall_o rises only when all are full
// reset puts every pump off with no timers and zero totals, and loads register defaults
module pump_safety_interlock import psi_pkg::*; #(
  parameter int NUM_PUMPS = NUM_PUMPS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  input  logic [1:0]        pump_index_i,
  input  logic [31:0]       now_ms_i,
  input  logic [6:0]        tank_level_i,
  input  logic              tank_err_i,
  input  logic [6:0]        soil_level_i,
  input  logic              soil_err_i,
  input  logic              desired_i,
  input  logic [15:0]       duration_sec_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        pump_echo_o,
  output logic              relay_on_o,
  output logic [2:0]        pump_state_o,
  output logic [2:0]        request_result_o,
  output logic [SECS_W-1:0] stopped_seconds_o,
  output logic [31:0]       run_seconds_today_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int PW = (NUM_PUMPS > 1) ? $clog2(NUM_PUMPS) : 1;

  // configuration registers
  logic [6:0]  min_water_q, soil_thr_q, hyst_q;
  logic        auto_mode_q;
  logic [15:0] max_pump_q, max_manual_q;
  logic [26:0] cooldown_q;
  logic [25:0] max_run_ms_q;
  logic        cfg_we;
  cfg_reg_e    cfg_sel;
  cfg_t        cfg;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_water_q  <= 7'd10;
      soil_thr_q   <= 7'd30;
      auto_mode_q  <= 1'b0;
      max_pump_q   <= 16'd600;
      max_run_ms_q <= 26'd600000;
      hyst_q       <= 7'd5;
      cooldown_q   <= 27'd60000;
      max_manual_q <= 16'd3600;
    end else if (cfg_we) begin
      case (cfg_sel)
        CFG_MIN_WATER:  min_water_q <= pwdata[6:0];
        CFG_SOIL_THR:   soil_thr_q  <= pwdata[6:0];
        CFG_AUTO_MODE:  auto_mode_q <= pwdata[0];
        CFG_MAX_PUMP: begin
          max_pump_q   <= pwdata[15:0];
          // run limit in ms kept ready for the trip compare
          max_run_ms_q <= {10'b0, pwdata[15:0]} * MS_PER_SEC;
        end
        CFG_HYST:       hyst_q       <= pwdata[6:0];
        CFG_COOLDOWN:   cooldown_q   <= pwdata[26:0];
        CFG_MAX_MANUAL: max_manual_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      CFG_MIN_WATER:  prdata = {25'b0, min_water_q};
      CFG_SOIL_THR:   prdata = {25'b0, soil_thr_q};
      CFG_AUTO_MODE:  prdata = {31'b0, auto_mode_q};
      CFG_MAX_PUMP:   prdata = {16'b0, max_pump_q};
      CFG_HYST:       prdata = {25'b0, hyst_q};
      CFG_COOLDOWN:   prdata = {5'b0, cooldown_q};
      CFG_MAX_MANUAL: prdata = {16'b0, max_manual_q};
      default:        prdata = '0;
    endcase
  end

  assign cfg.min_water  = min_water_q;
  assign cfg.soil_thr   = soil_thr_q;
  assign cfg.auto_mode  = auto_mode_q;
  assign cfg.max_run_ms = max_run_ms_q;
  assign cfg.hyst       = hyst_q;
  assign cfg.cooldown   = cooldown_q;

  // stage valids and the advance chain; an empty stage always takes the one before it
  logic v0_q, v1_q, v2_q, vo_q;
  logic mv1, mv2, mvo, accept;

  assign mvo        = v2_q && (!vo_q || !out_stall_i);
  assign mv2        = v1_q && (!v2_q || mvo);
  assign mv1        = v0_q && (!v1_q || mv2);
  assign in_stall_o = v0_q && !mv1;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (accept) v0_q <= 1'b1;
      else if (mv1) v0_q <= 1'b0;
      if (mv1) v1_q <= 1'b1;
      else if (mv2) v1_q <= 1'b0;
      if (mv2) v2_q <= 1'b1;
      else if (mvo) v2_q <= 1'b0;
      if (mvo) vo_q <= 1'b1;
      else if (out_valid_o && !out_stall_i) vo_q <= 1'b0;
    end
  end

  // stage 0: capture, manual duration capped and scaled to ms
  item_t          item0_q;
  logic [PW-1:0]  pidx0_q;
  logic [1:0]     pecho0_q;
  logic           inval0_q;
  logic [15:0]    dur_cap;

  assign dur_cap = (duration_sec_i > max_manual_q) ? max_manual_q : duration_sec_i;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item0_q.op       <= operation_i;
      item0_q.now      <= now_ms_i;
      item0_q.tank     <= tank_level_i;
      item0_q.tank_err <= tank_err_i;
      item0_q.soil     <= soil_level_i;
      item0_q.soil_err <= soil_err_i;
      item0_q.desired  <= desired_i;
      item0_q.dur_nz   <= (duration_sec_i != '0);
      item0_q.dur_ms   <= {10'b0, dur_cap} * MS_PER_SEC;
      pidx0_q          <= pump_index_i[PW-1:0];
      pecho0_q         <= pump_index_i;
      inval0_q         <= (int'(pump_index_i) >= NUM_PUMPS);
    end
  end

  // stage 1: per-pump state machine; state commits as the request moves on
  pump_st_t pst_q [NUM_PUMPS];
  step_t    step;

  psi_step u_step (
    .cfg_i  (cfg),
    .item_i (item0_q),
    .cur_i  (pst_q[pidx0_q]),
    .step_o (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PUMPS; i++) begin
        pst_q[i] <= '0;
      end
    end else if (mv1 && !inval0_q) begin
      pst_q[pidx0_q] <= step.st;
    end
  end

  logic [PW-1:0] pidx1_q;
  logic [1:0]    pecho1_q;
  logic          inval1_q, relay1_q;
  mode_e         mode1_q;
  res_e          res1_q;
  logic [31:0]   stop_ms1_q;

  always_ff @(posedge clk_i) begin
    if (mv1) begin
      pidx1_q  <= pidx0_q;
      pecho1_q <= pecho0_q;
      inval1_q <= inval0_q;
      if (inval0_q) begin
        relay1_q   <= 1'b0;
        mode1_q    <= MODE_OFF;
        res1_q     <= RES_INVALID;
        stop_ms1_q <= '0;
      end else begin
        relay1_q   <= step.st.relay;
        mode1_q    <= step.st.mode;
        res1_q     <= step.res;
        stop_ms1_q <= step.stop ? step.stop_ms : '0;
      end
    end
  end

  // stage 2: elapsed ms to whole seconds by reciprocal multiply
  logic [63:0]       prod;
  logic [PW-1:0]     pidx2_q;
  logic [1:0]        pecho2_q;
  logic              inval2_q, relay2_q;
  mode_e             mode2_q;
  res_e              res2_q;
  logic [SECS_W-1:0] secs2_q;

  assign prod = {32'b0, stop_ms1_q} * {32'b0, DIV1000_MUL};

  always_ff @(posedge clk_i) begin
    if (mv2) begin
      pidx2_q  <= pidx1_q;
      pecho2_q <= pecho1_q;
      inval2_q <= inval1_q;
      relay2_q <= relay1_q;
      mode2_q  <= mode1_q;
      res2_q   <= res1_q;
      secs2_q  <= prod[DIV1000_SH+SECS_W-1:DIV1000_SH];
    end
  end

  // stage 3: saturating run total, kept per pump in request order
  logic [31:0] total_q [NUM_PUMPS];
  logic [32:0] tsum;
  logic [31:0] total_d;

  assign tsum    = {1'b0, total_q[pidx2_q]} + {10'b0, secs2_q};
  assign total_d = tsum[32] ? '1 : tsum[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PUMPS; i++) begin
        total_q[i] <= '0;
      end
    end else if (mvo && !inval2_q) begin
      total_q[pidx2_q] <= total_d;
    end
  end

  logic [1:0]        pecho_o_q;
  logic              relay_o_q;
  mode_e             mode_o_q;
  res_e              res_o_q;
  logic [SECS_W-1:0] secs_o_q;
  logic [31:0]       total_o_q;

  always_ff @(posedge clk_i) begin
    if (mvo) begin
      pecho_o_q <= pecho2_q;
      relay_o_q <= relay2_q;
      mode_o_q  <= mode2_q;
      res_o_q   <= res2_q;
      secs_o_q  <= secs2_q;
      total_o_q <= inval2_q ? '0 : total_d;
    end
  end

  assign out_valid_o         = vo_q;
  assign pump_echo_o         = pecho_o_q;
  assign relay_on_o          = relay_o_q;
  assign pump_state_o        = mode_o_q;
  assign request_result_o    = res_o_q;
  assign stopped_seconds_o   = secs_o_q;
  assign run_seconds_today_o = total_o_q;

endmodule

/* src/psi_checker.sv */
module psi_checker import psi_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [1:0]        pump_echo_o,
  input logic              relay_on_o,
  input logic [2:0]        pump_state_o,
  input logic [2:0]        request_result_o,
  input logic [SECS_W-1:0] stopped_seconds_o,
  input logic [31:0]       run_seconds_today_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pump_echo_o)
      && $stable(pump_state_o) && $stable(run_seconds_today_o))
    else $error("stalled result changed");

  // an unknown pump reports nothing of any pump
  a_invalid_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && request_result_o == RES_INVALID |-> !relay_on_o
      && pump_state_o == MODE_OFF && stopped_seconds_o == '0 && run_seconds_today_o == '0)
    else $error("invalid pump result carries state");

  // relay energized exactly when the pump is on
  a_relay_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && request_result_o != RES_INVALID |-> relay_on_o == (pump_state_o == MODE_ON))
    else $error("relay and mode disagree");

  // a stopped run leaves the relay off
  a_stop_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stopped_seconds_o != '0 |-> !relay_on_o)
    else $error("relay on after a stop");

  // a denied request never stops a run
  a_deny_nostop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (request_result_o == RES_DRY || request_result_o == RES_SENSOR
      || request_result_o == RES_RUNTIME) |-> stopped_seconds_o == '0)
    else $error("denied request stopped a run");

endmodule

bind pump_safety_interlock psi_checker u_psi_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .pump_echo_o         (pump_echo_o),
  .relay_on_o          (relay_on_o),
  .pump_state_o        (pump_state_o),
  .request_result_o    (request_result_o),
  .stopped_seconds_o   (stopped_seconds_o),
  .run_seconds_today_o (run_seconds_today_o)
);

/* sim/pump_safety_interlock_tb.sv */
`timescale 1ns / 1ps

module pump_safety_interlock_tb;
  import psi_pkg::*;

  localparam int NP          = NUM_PUMPS_DEF;
  localparam int LONG_HOLD   = 400;     // cycles the result side holds off under pressure
  localparam int DRAIN_WAIT  = 12;      // pipeline is four stages deep
  localparam int RUN_LIMIT   = 200000;  // worst case is well under this

  // request kinds on the input channel
  typedef enum bit {
    OP_TICK   = 1'b0,
    OP_MANUAL = 1'b1
  } op_e;

  // one request as sent to the block
  typedef struct {
    op_e       op;
    bit [1:0]  pump;
    bit [31:0] now;
    bit [6:0]  tank;
    bit        terr;
    bit [6:0]  soil;
    bit        serr;
    bit        want;
    bit [15:0] dur;
  } pump_cmd_t;

  // one pump status word as it should leave the block
  typedef struct {
    bit [1:0]        pump;
    bit              relay;
    mode_e           state;
    res_e            res;
    bit [SECS_W-1:0] stopped;
    bit [31:0]       total;
  } pump_status_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #10 clk_i = ~clk_i;

  // input channel
  logic              in_valid_i     = 1'b0;
  logic              in_stall_o;
  logic              operation_i    = 1'b0;
  logic [1:0]        pump_index_i   = '0;
  logic [31:0]       now_ms_i       = '0;
  logic [6:0]        tank_level_i   = '0;
  logic              tank_err_i     = 1'b0;
  logic [6:0]        soil_level_i   = '0;
  logic              soil_err_i     = 1'b0;
  logic              desired_i      = 1'b0;
  logic [15:0]       duration_sec_i = '0;

  // result channel
  logic              out_valid_o;
  logic              out_stall_i    = 1'b0;
  logic [1:0]        pump_echo_o;
  logic              relay_on_o;
  logic [2:0]        pump_state_o;
  logic [2:0]        request_result_o;
  logic [SECS_W-1:0] stopped_seconds_o;
  logic [31:0]       run_seconds_today_o;

  // register port
  logic              psel           = 1'b0;
  logic              penable        = 1'b0;
  logic              pwrite         = 1'b0;
  logic [CFG_AW-1:0] paddr          = '0;
  logic [31:0]       pwdata         = '0;
  logic [31:0]       prdata;
  logic              pready;

  pump_safety_interlock #(
    .NUM_PUMPS(NP)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .pump_index_i       (pump_index_i),
    .now_ms_i           (now_ms_i),
    .tank_level_i       (tank_level_i),
    .tank_err_i         (tank_err_i),
    .soil_level_i       (soil_level_i),
    .soil_err_i         (soil_err_i),
    .desired_i          (desired_i),
    .duration_sec_i     (duration_sec_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .pump_echo_o        (pump_echo_o),
    .relay_on_o         (relay_on_o),
    .pump_state_o       (pump_state_o),
    .request_result_o   (request_result_o),
    .stopped_seconds_o  (stopped_seconds_o),
    .run_seconds_today_o(run_seconds_today_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // shadow of the register file, loaded with the reset defaults
  bit [6:0]  cf_min_water  = 7'd10;
  bit [6:0]  cf_soil_thr   = 7'd30;
  bit        cf_auto       = 1'b0;
  bit [15:0] cf_max_pump   = 16'd600;
  bit [6:0]  cf_hyst       = 7'd5;
  bit [26:0] cf_cooldown   = 27'd60000;
  bit [15:0] cf_max_manual = 16'd3600;

  // per-pump interlock state kept by the testbench
  mode_e     pm_mode    [NP];
  bit        pm_relay   [NP];
  bit        pm_demand  [NP];
  bit [31:0] pm_start   [NP];
  bit [31:0] pm_lock_dl [NP];
  bit [31:0] pm_run_dl  [NP];
  bit [31:0] pm_total   [NP];
  bit [31:0] stop_el_s;

  pump_status_t status_q[$];
  pump_status_t got_status;
  int           mismatch_count = 0;
  int unsigned  cycle_count    = 0;
  bit [31:0]    t_now          = '0;

  // traffic shaping
  bit           idle_on        = 1'b1;
  int           hold_left      = 0;
  int           long_asked     = 0;
  int           long_seen      = 0;

  // deadline still ahead of now, wrap-safe; zero means no deadline
  function automatic bit timer_pending(bit [31:0] now, bit [31:0] dl);
    bit [31:0] d;
    d = dl - now;
    return (dl != 0) && (d != 0) && !d[31];
  endfunction

  // zero is reserved for no deadline, so a deadline landing there moves to one
  function automatic bit [31:0] timer_at(bit [31:0] now, bit [31:0] ofs);
    bit [31:0] d;
    d = now + ofs;
    return (d == 0) ? 32'd1 : d;
  endfunction

  // switch the relay, account the finished run into the saturating daily total
  function automatic void drive_relay(int p, bit on, bit [31:0] now);
    bit [31:0] el;
    bit [31:0] sum;
    if (pm_relay[p] == on) return;
    pm_relay[p] = on;
    if (on) begin
      pm_start[p] = now;
      return;
    end
    // a run started at time zero is untimed and adds nothing
    if (pm_start[p] != 0) begin
      el  = (now - pm_start[p]) / MS_PER_SEC;
      sum = pm_total[p] + el;
      if (sum < pm_total[p]) sum = '1;
      pm_total[p] = sum;
      stop_el_s   = el;
    end
    pm_start[p] = '0;
  endfunction

  // apply one request to the pump state and return the status it produces
  function automatic pump_status_t interlock_step(pump_cmd_t c);
    pump_status_t s;
    int           p;
    int unsigned  tank_u, soil_u, rel_lvl, secs, limit_ms;
    s.pump    = c.pump;
    s.relay   = 1'b0;
    s.state   = MODE_OFF;
    s.res     = RES_GRANTED;
    s.stopped = '0;
    s.total   = '0;
    // out-of-range pump touches nothing
    if (c.pump >= NP) begin
      s.res = RES_INVALID;
      return s;
    end
    p         = c.pump;
    tank_u    = c.tank;
    soil_u    = c.soil;
    stop_el_s = '0;
    if (c.op == OP_TICK) begin
      // hard lockouts, then release of lockouts
      if (c.terr) begin
        drive_relay(p, 1'b0, c.now);
        pm_mode[p] = MODE_SENSOR;
      end else if (tank_u < cf_min_water) begin
        drive_relay(p, 1'b0, c.now);
        pm_mode[p] = MODE_DRY;
      end else if (pm_mode[p] == MODE_RUNTIME &&
                   timer_pending(c.now, pm_lock_dl[p])) begin
        drive_relay(p, 1'b0, c.now);
      end else begin
        if (pm_mode[p] == MODE_DRY && tank_u >= cf_min_water + cf_hyst)
          pm_mode[p] = MODE_OFF;
        if (pm_mode[p] == MODE_SENSOR) pm_mode[p] = MODE_OFF;
        if (pm_mode[p] == MODE_RUNTIME) begin
          pm_mode[p]    = MODE_OFF;
          pm_lock_dl[p] = '0;
        end
      end
      // soil demand with a hysteresis band capped at full scale
      if (cf_auto) begin
        rel_lvl = cf_soil_thr + cf_hyst;
        if (rel_lvl > PCT_MAX) rel_lvl = PCT_MAX;
        if (c.serr) pm_demand[p] = 1'b0;
        else if (soil_u < cf_soil_thr) pm_demand[p] = 1'b1;
        else if (soil_u > rel_lvl) pm_demand[p] = 1'b0;
      end
      // manual run timer and demand following
      if (pm_mode[p] == MODE_OFF || pm_mode[p] == MODE_ON) begin
        if (pm_run_dl[p] != 0 && !timer_pending(c.now, pm_run_dl[p])) begin
          if (pm_relay[p]) drive_relay(p, 1'b0, c.now);
          pm_mode[p]   = MODE_OFF;
          pm_run_dl[p] = '0;
          pm_demand[p] = 1'b0;
        end else if (pm_demand[p] && !pm_relay[p]) begin
          drive_relay(p, 1'b1, c.now);
          pm_mode[p] = MODE_ON;
        end else if (!pm_demand[p] && pm_relay[p]) begin
          drive_relay(p, 1'b0, c.now);
          pm_mode[p]   = MODE_OFF;
          pm_run_dl[p] = '0;
        end
      end
      // continuous runtime trip arms the cooldown
      limit_ms = cf_max_pump * MS_PER_SEC;
      if (pm_mode[p] == MODE_ON && pm_start[p] != 0 &&
          c.now - pm_start[p] >= limit_ms) begin
        drive_relay(p, 1'b0, c.now);
        pm_mode[p]    = MODE_RUNTIME;
        pm_run_dl[p]  = '0;
        pm_lock_dl[p] = timer_at(c.now, cf_cooldown);
        pm_demand[p]  = 1'b0;
      end
    end else if (!c.want) begin
      // forced off: drop demand and timer, relay follows on the next tick
      pm_demand[p] = 1'b0;
      pm_run_dl[p] = '0;
    end else begin
      if (c.terr) s.res = RES_SENSOR;
      else if (tank_u < cf_min_water) s.res = RES_DRY;
      else if (pm_mode[p] == MODE_RUNTIME) s.res = RES_RUNTIME;
      else if (pm_mode[p] == MODE_SENSOR) s.res = RES_SENSOR;
      else if (pm_mode[p] == MODE_DRY) s.res = RES_DRY;
      if (s.res == RES_GRANTED) begin
        pm_demand[p] = 1'b1;
        if (c.dur != 0) begin
          secs = c.dur;
          if (secs > cf_max_manual) secs = cf_max_manual;
          pm_run_dl[p] = timer_at(c.now, secs * MS_PER_SEC);
        end else begin
          pm_run_dl[p] = '0;
        end
      end
    end
    s.relay   = pm_relay[p];
    s.state   = pm_mode[p];
    s.stopped = stop_el_s[SECS_W-1:0];
    s.total   = pm_total[p];
    return s;
  endfunction

  function automatic pump_cmd_t mk_tick(bit [1:0] p, bit [31:0] now, bit [6:0] tank,
                                        bit terr, bit [6:0] soil, bit serr);
    pump_cmd_t c;
    c.op   = OP_TICK;
    c.pump = p;
    c.now  = now;
    c.tank = tank;
    c.terr = terr;
    c.soil = soil;
    c.serr = serr;
    c.want = 1'b0;
    c.dur  = '0;
    return c;
  endfunction

  function automatic pump_cmd_t mk_manual(bit [1:0] p, bit [31:0] now, bit [6:0] tank,
                                          bit terr, bit want, bit [15:0] dur);
    pump_cmd_t c;
    c      = mk_tick(p, now, tank, terr, 7'd50, 1'b0);
    c.op   = OP_MANUAL;
    c.want = want;
    c.dur  = dur;
    return c;
  endfunction

  // mostly sane plant behavior: time moves forward on the scale of the
  // configured limits, sensors mostly healthy, tank mostly above the dry limit
  function automatic pump_cmd_t random_cmd();
    pump_cmd_t   c;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) t_now += $urandom_range(0, 1500);
    else if (r < 80) t_now += $urandom_range(0, cf_max_pump * MS_PER_SEC + 1000);
    else if (r < 93) t_now += $urandom_range(0, cf_cooldown + 2000);
    else if (r < 97) t_now += $urandom;
    else if (r < 98) t_now = '0;
    else t_now -= $urandom_range(0, 5000);
    c.op   = ($urandom_range(0, 99) < 40) ? OP_MANUAL : OP_TICK;
    c.pump = ($urandom_range(0, 99) < 8) ? $urandom_range(NP, 3) : $urandom_range(0, NP - 1);
    c.now  = t_now;
    c.tank = ($urandom_range(0, 99) < 75) ? $urandom_range(cf_min_water, PCT_MAX)
                                          : $urandom_range(0, PCT_MAX);
    c.terr = ($urandom_range(0, 99) < 6);
    c.soil = $urandom_range(0, PCT_MAX);
    c.serr = ($urandom_range(0, 99) < 6);
    c.want = ($urandom_range(0, 99) < 80);
    r = $urandom_range(0, 99);
    c.dur  = (r < 30) ? 16'd0 : (r < 80) ? $urandom_range(1, 8) : $urandom_range(0, 65535);
    return c;
  endfunction

  // one request over the valid/stall handshake, predicted once it is taken
  task automatic send_request(pump_cmd_t c);
    bit taken;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= c.op;
    pump_index_i   <= c.pump;
    now_ms_i       <= c.now;
    tank_level_i   <= c.tank;
    tank_err_i     <= c.terr;
    soil_level_i   <= c.soil;
    soil_err_i     <= c.serr;
    desired_i      <= c.want;
    duration_sec_i <= c.dur;
    // stall is settled mid-cycle, the request goes in at the next rising edge
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    status_q.push_back(interlock_step(c));
  endtask

  // stop offering and wait for every outstanding status
  task automatic wait_results();
    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
  endtask

  // setup then access phase; the shadow follows once the access completes
  task automatic write_reg(cfg_reg_e idx, bit [31:0] val);
    bit done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      done = pready;
      @(posedge clk_i);
    end while (!done);
    case (idx)
      CFG_MIN_WATER:  cf_min_water  = val[6:0];
      CFG_SOIL_THR:   cf_soil_thr   = val[6:0];
      CFG_AUTO_MODE:  cf_auto       = val[0];
      CFG_MAX_PUMP:   cf_max_pump   = val[15:0];
      CFG_HYST:       cf_hyst       = val[6:0];
      CFG_COOLDOWN:   cf_cooldown   = val[26:0];
      CFG_MAX_MANUAL: cf_max_manual = val[15:0];
      default: ;
    endcase
  endtask

  // rewrite the whole register file, only ever called with the block drained
  task automatic apply_config(int unsigned min_water, int unsigned soil_thr,
                              int unsigned auto_on, int unsigned max_pump,
                              int unsigned hyst, int unsigned cooldown,
                              int unsigned max_manual);
    write_reg(CFG_MIN_WATER, min_water);
    write_reg(CFG_SOIL_THR, soil_thr);
    write_reg(CFG_AUTO_MODE, auto_on);
    write_reg(CFG_MAX_PUMP, max_pump);
    write_reg(CFG_HYST, hyst);
    write_reg(CFG_COOLDOWN, cooldown);
    write_reg(CFG_MAX_MANUAL, max_manual);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_random(int n);
    t_now = $urandom;
    repeat (n) send_request(random_cmd());
    wait_results();
  endtask

  // walk the state machine by hand at the reset settings
  task automatic test_directed();
    send_request(mk_tick(0, 32'd1000, 7'd50, 1'b0, 7'd50, 1'b0));
    // pumps past the configured count
    send_request(mk_manual(2, 32'd1100, 7'd50, 1'b0, 1'b1, 16'd10));
    send_request(mk_tick(3, 32'd1200, 7'd100, 1'b0, 7'd100, 1'b0));
    // unlimited manual run, re-armed while on, then a runtime trip
    send_request(mk_manual(0, 32'd2000, 7'd50, 1'b0, 1'b1, 16'd0));
    send_request(mk_tick(0, 32'd3000, 7'd50, 1'b0, 7'd50, 1'b0));
    send_request(mk_manual(0, 32'd4000, 7'd50, 1'b0, 1'b1, 16'd0));
    send_request(mk_tick(0, 32'd603000, 7'd50, 1'b0, 7'd50, 1'b0));
    send_request(mk_manual(0, 32'd604000, 7'd50, 1'b0, 1'b1, 16'd5));
    send_request(mk_tick(0, 32'd620000, 7'd50, 1'b0, 7'd50, 1'b0));
    send_request(mk_tick(0, 32'd663001, 7'd50, 1'b0, 7'd50, 1'b0));
    // sensor lockout and its denials
    send_request(mk_tick(0, 32'd664000, 7'd50, 1'b1, 7'd50, 1'b0));
    send_request(mk_manual(0, 32'd665000, 7'd50, 1'b0, 1'b1, 16'd0));
    send_request(mk_manual(0, 32'd665500, 7'd50, 1'b1, 1'b1, 16'd0));
    // dry-run lockout, held inside the hysteresis band, released at its edge
    send_request(mk_tick(0, 32'd666000, 7'd9, 1'b0, 7'd50, 1'b0));
    send_request(mk_manual(0, 32'd667000, 7'd12, 1'b0, 1'b1, 16'd0));
    send_request(mk_manual(0, 32'd667500, 7'd0, 1'b0, 1'b1, 16'd0));
    send_request(mk_tick(0, 32'd668000, 7'd14, 1'b0, 7'd50, 1'b0));
    send_request(mk_tick(0, 32'd669000, 7'd15, 1'b0, 7'd50, 1'b0));
    // longest duration gets capped, timer found expired once its deadline has passed
    send_request(mk_manual(0, 32'd670000, 7'd50, 1'b0, 1'b1, 16'hFFFF));
    send_request(mk_tick(0, 32'd671000, 7'd50, 1'b0, 7'd50, 1'b0));
    send_request(mk_tick(0, 32'd4271000, 7'd50, 1'b0, 7'd50, 1'b0));
    // run started at time zero is never timed
    send_request(mk_manual(1, 32'd0, 7'd100, 1'b0, 1'b1, 16'd0));
    send_request(mk_tick(1, 32'd0, 7'd100, 1'b0, 7'd0, 1'b1));
    send_request(mk_tick(1, 32'd900000000, 7'd100, 1'b0, 7'd100, 1'b0));
    // deadline wrapping onto zero, checked across the wrap
    send_request(mk_manual(1, 32'hFFFF_FC18, 7'd100, 1'b0, 1'b1, 16'd1));
    send_request(mk_tick(1, 32'hFFFF_FFFF, 7'd100, 1'b0, 7'd100, 1'b0));
    send_request(mk_tick(1, 32'd1, 7'd100, 1'b0, 7'd100, 1'b0));
    send_request(mk_manual(0, 32'd5000000, 7'd50, 1'b0, 1'b0, 16'd0));
    wait_results();
  endtask

  // short limits so manual runs, caps, trips and cooldowns recur often
  task automatic test_manual_mode();
    apply_config(10, 30, 0, 3, 5, 4000, 2);
    run_random(160);
  endtask

  // soil driven demand, manual commands only nudge the latch
  task automatic test_auto_mode();
    apply_config(20, 50, 1, 5, 10, 3000, 4);
    run_random(160);
  endtask

  // zero cap and zero limit, no cooldown, no hysteresis, top dry limit
  task automatic test_zero_limits();
    apply_config(100, 0, 0, 0, 0, 0, 0);
    run_random(130);
  endtask

  // widest limits and longest cooldown, release band clamped at full scale
  task automatic test_top_limits();
    apply_config(0, 100, 1, 65535, 100, 86400000, 65535);
    run_random(130);
  endtask

  // random register values, one pass with idling and one without
  task automatic test_random_settings();
    repeat (2) begin
      apply_config($urandom_range(0, 100), $urandom_range(0, 100), $urandom_range(0, 1),
                   $urandom_range(1, 20), $urandom_range(0, 30),
                   $urandom_range(0, 20000), $urandom_range(1, 20));
      run_random(100);
      idle_on <= ~idle_on;
    end
  endtask

  // result side holds off long enough for the pipe to fill and stall the input
  task automatic test_backpressure();
    idle_on    <= 1'b0;
    long_asked <= long_asked + 1;
    t_now = $urandom;
    repeat (40) send_request(random_cmd());
    wait_results();
    idle_on    <= 1'b1;
  endtask

  // sender goes quiet mid-stream until everything is back
  task automatic test_sender_pause();
    t_now = $urandom;
    repeat (20) send_request(random_cmd());
    wait_results();
    repeat (20) send_request(random_cmd());
    wait_results();
  endtask

  // back-to-back traffic, no idling on either side
  task automatic test_quiet_tail();
    idle_on <= 1'b0;
    run_random(80);
  endtask

  // result side: random stall bursts, plus a long hold on demand
  always @(posedge clk_i) begin
    if (long_asked != long_seen) begin
      long_seen   <= long_asked;
      hold_left   <= LONG_HOLD;
      out_stall_i <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      hold_left   <= $urandom_range(1, 18);
      out_stall_i <= 1'b1;
    end else begin
      hold_left   <= 0;
      out_stall_i <= 1'b0;
    end
  end

  // compare each status taken at the next edge against the oldest prediction
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (status_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected status: pump %0d relay %0d state %0d res %0d",
                   pump_echo_o, relay_on_o, pump_state_o, request_result_o);
      end else begin
        got_status = status_q.pop_front();
        if (pump_echo_o !== got_status.pump || relay_on_o !== got_status.relay ||
            pump_state_o !== got_status.state || request_result_o !== got_status.res ||
            stopped_seconds_o !== got_status.stopped ||
            run_seconds_today_o !== got_status.total) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"status mismatch: exp pump %0d relay %0d state %0d res %0d ",
                      "stop %0d total %0d, got pump %0d relay %0d state %0d res %0d ",
                      "stop %0d total %0d"},
                     got_status.pump, got_status.relay, got_status.state,
                     got_status.res, got_status.stopped, got_status.total,
                     pump_echo_o, relay_on_o, pump_state_o, request_result_o,
                     stopped_seconds_o, run_seconds_today_o);
        end
      end
    end
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // watchdog
  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    for (int i = 0; i < NP; i++) pm_mode[i] = MODE_OFF;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_manual_mode();
    test_auto_mode();
    test_zero_limits();
    test_top_limits();
    test_random_settings();
    test_backpressure();
    test_sender_pause();
    test_quiet_tail();
    wait_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_count == 0 && status_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/psi_pkg.sv
src/psi_step.sv
src/pump_safety_interlock.sv
src/psi_checker.sv
sim/pump_safety_interlock_tb.sv
